// ===== hw/rtl/mcoq_pkg.sv =====
// Shared constants, widths and the face record for the cell orthogonal quality block.
`default_nettype none
package mcoq_pkg;
   localparam int COORD_BITS = 32;
   localparam int QUALITY_FRAC_BITS = 15;
   localparam int QUALITY_BITS = QUALITY_FRAC_BITS + 1;

   // Offset vector components are one bit wider than the coordinates.
   localparam int D_W = COORD_BITS + 1;
   localparam int PDN_W = D_W + COORD_BITS;
   localparam int SDOT_W = 2 * COORD_BITS + 2;
   localparam int DOT_W = 2 * COORD_BITS + 1;
   localparam int D2_W = 2 * COORD_BITS + 2;
   localparam int N2_W = 2 * COORD_BITS;
   localparam int P_W = D2_W + N2_W;
   localparam int SQ_W = 2 * DOT_W;
   localparam int R_W = SQ_W + 2 * QUALITY_FRAC_BITS;
   localparam int T_W = P_W + 2 * QUALITY_BITS + 1;
   localparam int MUL_STEPS = DOT_W;
   localparam int MUL_CNT_W = $clog2(MUL_STEPS);
   localparam int K_W = $clog2(QUALITY_BITS);

   // Queue depth must be a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = ((9 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((QUALITY_BITS + 7) / 8) * 8;

   localparam logic [QUALITY_BITS-1:0] QUALITY_ONE = QUALITY_BITS'(1) << QUALITY_FRAC_BITS;

   typedef struct packed {
      logic [2:0][D_W-1:0]        d;
      logic [2:0][COORD_BITS-1:0] n;
      logic                       last;
   } face_type;
endpackage
`default_nettype wire

// ===== hw/rtl/mcoq_fifo.sv =====
// Short queue of faces (offset vector, normal, last flag) between the front and back parts.
`default_nettype none
module mcoq_fifo
   import mcoq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire face_type wr_entry,
   input  wire logic     pop,
   output logic          full,
   output logic          valid,
   output face_type      rd_entry
);
   face_type              entries_ff [QUEUE_DEPTH];
   face_type              entries_in [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign rd_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         entries_in[wr_ptr_ff] = wr_entry;
         wr_ptr_in = QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/mcoq_front.sv =====
// Front part: accepts faces, forms the offset vector and queues the face.
`default_nettype none
module mcoq_front
   import mcoq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   input  wire logic                  q_pop,
   output logic                       q_valid,
   output face_type                   q_entry
);
   face_type wr_entry;
   logic     full;
   logic     push;

   always_comb begin
      wr_entry.last = req_tlast;
      for (int k = 0; k < 3; k++) begin
         wr_entry.d[k] = D_W'($signed(req_tdata[(3 + k) * COORD_BITS +: COORD_BITS]))
                       - D_W'($signed(req_tdata[k * COORD_BITS +: COORD_BITS]));
         wr_entry.n[k] = req_tdata[(6 + k) * COORD_BITS +: COORD_BITS];
      end
   end

   assign req_tready = !full;
   assign push = req_tvalid && !full;

   mcoq_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (wr_entry),
      .pop      (q_pop),
      .full     (full),
      .valid    (q_valid),
      .rd_entry (q_entry)
   );
endmodule
`default_nettype wire

// ===== hw/rtl/mcoq_back.sv =====
// Back part: face products, shift-add squares and bit-serial cosine search, cell minimum.
`default_nettype none
module mcoq_back
   import mcoq_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  wire face_type               q_entry,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic                        rsp_tuser
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_PROD, ST_CHECK, ST_MUL, ST_LOAD, ST_TRY, ST_CMP, ST_UPDATE
   } state_type;

   state_type                 state_ff, state_in;
   face_type                  face_ff, face_in;
   logic [1:0]                step_ff, step_in;
   logic signed [PDN_W-1:0]   pdn_ff, pdn_in;
   logic [D2_W-1:0]           pdd_ff, pdd_in;
   logic [N2_W-1:0]           pnn_ff, pnn_in;
   logic signed [SDOT_W-1:0]  sdot_ff, sdot_in;
   logic [D2_W-1:0]           d2_ff, d2_in;
   logic [N2_W-1:0]           n2_ff, n2_in;
   logic [SQ_W-1:0]           mca_ff, mca_in, acca_ff, acca_in;
   logic [DOT_W-1:0]          mpa_ff, mpa_in;
   logic [P_W-1:0]            mcb_ff, mcb_in, accb_ff, accb_in;
   logic [N2_W-1:0]           mpb_ff, mpb_in;
   logic [MUL_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [R_W-1:0]            e_ff, e_in;
   logic [T_W-1:0]            a_ff, a_in, b_ff, b_in, t_ff, t_in;
   logic [QUALITY_BITS-1:0]   q_ff, q_in;
   logic [K_W-1:0]            k_ff, k_in;
   logic                      fdeg_ff, fdeg_in;
   logic [QUALITY_BITS-1:0]   min_ff, min_in;
   logic                      dseen_ff, dseen_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [QUALITY_BITS-1:0]   rsp_q_ff, rsp_q_in;
   logic                      rsp_deg_ff, rsp_deg_in;

   logic [1:0]                axis;
   logic signed [D_W-1:0]     d_sel;
   logic signed [COORD_BITS-1:0] n_sel;
   logic signed [PDN_W-1:0]   prod_dn;
   logic signed [2*D_W-1:0]   prod_dd;
   logic signed [N2_W-1:0]    prod_nn;
   logic [SDOT_W-1:0]         dot_mag;
   logic [QUALITY_BITS-1:0]   new_min;

   assign axis = (step_ff == 2'd3) ? 2'd0 : step_ff;
   assign d_sel = $signed(face_ff.d[axis]);
   assign n_sel = $signed(face_ff.n[axis]);
   assign prod_dn = d_sel * n_sel;
   assign prod_dd = d_sel * d_sel;
   assign prod_nn = n_sel * n_sel;
   assign dot_mag = sdot_ff[SDOT_W-1] ? SDOT_W'(-sdot_ff) : SDOT_W'(sdot_ff);
   assign new_min = (q_ff < min_ff) ? q_ff : min_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RSP_DATA_W'(rsp_q_ff);
   assign rsp_tuser = rsp_deg_ff;

   always_comb begin
      state_in = state_ff;
      face_in = face_ff;
      step_in = step_ff;
      pdn_in = prod_dn;
      pdd_in = D2_W'(prod_dd);
      pnn_in = N2_W'(prod_nn);
      sdot_in = sdot_ff;
      d2_in = d2_ff;
      n2_in = n2_ff;
      mca_in = mca_ff;
      mpa_in = mpa_ff;
      acca_in = acca_ff;
      mcb_in = mcb_ff;
      mpb_in = mpb_ff;
      accb_in = accb_ff;
      cnt_in = cnt_ff;
      e_in = e_ff;
      a_in = a_ff;
      b_in = b_ff;
      t_in = t_ff;
      q_in = q_ff;
      k_in = k_ff;
      fdeg_in = fdeg_ff;
      min_in = min_ff;
      dseen_in = dseen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_q_in = rsp_q_ff;
      rsp_deg_in = rsp_deg_ff;
      q_pop = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               face_in = q_entry;
               step_in = '0;
               sdot_in = '0;
               d2_in = '0;
               n2_in = '0;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            // Products of one axis per cycle; the sums add each axis's products in the cycle after.
            if (step_ff != 2'd0) begin
               sdot_in = sdot_ff + SDOT_W'(pdn_ff);
               d2_in = d2_ff + pdd_ff;
               n2_in = n2_ff + pnn_ff;
            end
            step_in = 2'(step_ff + 1'b1);
            if (step_ff == 2'd3) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (d2_ff == '0 || n2_ff == '0) begin
               q_in = '0;
               fdeg_in = 1'b1;
               state_in = ST_UPDATE;
            end else begin
               fdeg_in = 1'b0;
               mca_in = SQ_W'(dot_mag[DOT_W-1:0]);
               mpa_in = dot_mag[DOT_W-1:0];
               acca_in = '0;
               mcb_in = P_W'(d2_ff);
               mpb_in = n2_ff;
               accb_in = '0;
               cnt_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // Dot squared and |N|^2 * |D|^2, one multiplier bit per cycle.
            if (mpa_ff[0]) acca_in = acca_ff + mca_ff;
            if (mpb_ff[0]) accb_in = accb_ff + mcb_ff;
            mca_in = mca_ff << 1;
            mpa_in = mpa_ff >> 1;
            mcb_in = mcb_ff << 1;
            mpb_in = mpb_ff >> 1;
            cnt_in = MUL_CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == MUL_CNT_W'(MUL_STEPS - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            e_in = {acca_ff, {(2 * QUALITY_FRAC_BITS){1'b0}}};
            b_in = T_W'({accb_ff, {(2 * QUALITY_FRAC_BITS){1'b0}}});
            a_in = '0;
            q_in = '0;
            k_in = K_W'(QUALITY_BITS - 1);
            state_in = ST_TRY;
         end
         ST_TRY: begin
            // Growth of q^2 * P when bit k is set: 2^(k+1) q P + 2^(2k) P.
            t_in = a_ff + b_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (T_W'(e_ff) >= t_ff) begin
               e_in = e_ff - R_W'(t_ff);
               a_in = (a_ff >> 1) + b_ff;
               q_in[k_ff] = 1'b1;
            end else begin
               a_in = a_ff >> 1;
            end
            b_in = b_ff >> 2;
            if (k_ff == '0) begin
               state_in = ST_UPDATE;
            end else begin
               k_in = K_W'(k_ff - 1'b1);
               state_in = ST_TRY;
            end
         end
         ST_UPDATE: begin
            if (!face_ff.last) begin
               min_in = new_min;
               dseen_in = dseen_ff | fdeg_ff;
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_q_in = new_min;
               rsp_deg_in = dseen_ff | fdeg_ff;
               rsp_valid_in = 1'b1;
               min_in = QUALITY_ONE;
               dseen_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      face_ff <= face_in;
      step_ff <= step_in;
      pdn_ff <= pdn_in;
      pdd_ff <= pdd_in;
      pnn_ff <= pnn_in;
      sdot_ff <= sdot_in;
      d2_ff <= d2_in;
      n2_ff <= n2_in;
      mca_ff <= mca_in;
      mpa_ff <= mpa_in;
      acca_ff <= acca_in;
      mcb_ff <= mcb_in;
      mpb_ff <= mpb_in;
      accb_ff <= accb_in;
      cnt_ff <= cnt_in;
      e_ff <= e_in;
      a_ff <= a_in;
      b_ff <= b_in;
      t_ff <= t_in;
      q_ff <= q_in;
      k_ff <= k_in;
      fdeg_ff <= fdeg_in;
      rsp_q_ff <= rsp_q_in;
      rsp_deg_ff <= rsp_deg_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         min_ff <= QUALITY_ONE;
         dseen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         min_ff <= min_in;
         dseen_ff <= dseen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/mesh_cell_orthogonal_quality.sv =====
// Each face passes through the back part's states in turn: fetch, per-axis products, check,
// one-bit-per-cycle squaring, then the bit-serial cosine search with a try and a compare state per bit;
// a degenerate face skips the squaring and the search. The front queues up to two faces meanwhile.
// A cell result is registered when its last face finishes and waits in an output register.
// Synchronous reset empties the queue, drops any pending result, and restores the
// running minimum to 1.0 with the degenerate mark cleared.
`default_nettype none
module mesh_cell_orthogonal_quality
   import mcoq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // cell_cx, cell_cy, cell_cz, face_cx, face_cy, face_cz, normal_x, normal_y, normal_z
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // quality
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // degenerate
   output logic                       rsp_tuser
);
   logic     q_pop;
   logic     q_valid;
   face_type q_entry;

   mcoq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_pop      (q_pop),
      .q_valid    (q_valid),
      .q_entry    (q_entry)
   );

   mcoq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule
`default_nettype wire
